[hw/rtl/wasi_pkg.sv]
package wasi_pkg;

    // Circle geometry; the angle field width fixes the circle size.
    localparam int ANG_W         = 12;
    localparam int CIRCLE_COUNTS = 1 << ANG_W;
    localparam int HALF_CIRCLE   = CIRCLE_COUNTS / 2;

    // Field and state widths
    localparam int FUNC_W = 2;
    localparam int DT_W   = 16;
    localparam int OFF_W  = 13;
    localparam int PT_W   = 16;
    localparam int IVL_W  = 17;
    localparam int CHG_W  = PT_W + 1;
    localparam int SPD_W  = 8;
    localparam int NUM_W  = 32;

    // Speed limit unit is counts per 32 time units
    localparam int SPEED_UNIT  = 32;
    localparam int SPEED_SHIFT = $clog2(SPEED_UNIT);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL = 1'd1;
    localparam logic [SPD_W-1:0]     MAX_SPEED_RST    = '0;
    localparam logic [DT_W-1:0]      MAX_INTERVAL_RST = 16'd1000;

    // Item function codes
    localparam logic [FUNC_W-1:0] FN_TARGET = 2'd0;
    localparam logic [FUNC_W-1:0] FN_TICK   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_SET    = 2'd2;
    localparam logic [FUNC_W-1:0] FN_ADJ    = 2'd3;

    // Datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
    localparam logic [OP_W-1:0] OP_NT_SP     = 4'd1;
    localparam logic [OP_W-1:0] OP_NT_UNWRAP = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV_RATE  = 4'd3;
    localparam logic [OP_W-1:0] OP_DIV_SPEED = 4'd4;
    localparam logic [OP_W-1:0] OP_SET_IVL   = 4'd5;
    localparam logic [OP_W-1:0] OP_NT_COMMIT = 4'd6;
    localparam logic [OP_W-1:0] OP_TICK_MUL  = 4'd7;
    localparam logic [OP_W-1:0] OP_DIV_TICK  = 4'd8;
    localparam logic [OP_W-1:0] OP_TICK_SP   = 4'd9;
    localparam logic [OP_W-1:0] OP_OFS_SET   = 4'd10;
    localparam logic [OP_W-1:0] OP_OFS_ADJ   = 4'd11;
    localparam logic [OP_W-1:0] OP_FINISH    = 4'd12;

    // Jump conditions
    localparam int JC_W = 4;
    localparam logic [JC_W-1:0] J_NEVER    = 4'd0;
    localparam logic [JC_W-1:0] J_ALWAYS   = 4'd1;
    localparam logic [JC_W-1:0] J_TICK     = 4'd2;
    localparam logic [JC_W-1:0] J_SET      = 4'd3;
    localparam logic [JC_W-1:0] J_ADJ      = 4'd4;
    localparam logic [JC_W-1:0] J_NO_LIMIT = 4'd5;
    localparam logic [JC_W-1:0] J_DIV_BUSY = 4'd6;
    localparam logic [JC_W-1:0] J_RATE_OK  = 4'd7;
    localparam logic [JC_W-1:0] J_OUT_BUSY = 4'd8;

    // Program counter
    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] PC_START = 5'd0;
    localparam logic [PC_W-1:0] PC_LAST  = 5'd19;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [JC_W-1:0] jc;
        logic [PC_W-1:0] target;
    } cw_t;

    typedef struct packed {
        logic            load;
        logic [OP_W-1:0] op;
    } ctrl_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              div_busy;
        logic              rate_ok;
    } stat_t;

endpackage

[hw/rtl/wasi_ucode_rom.sv]
module wasi_ucode_rom (
    input  logic [wasi_pkg::PC_W-1:0] pc,
    output wasi_pkg::cw_t             cw
);
    import wasi_pkg::*;

    localparam logic [PC_W-1:0] A_NT         = 5'd3;
    localparam logic [PC_W-1:0] A_RATE_WAIT  = 5'd7;
    localparam logic [PC_W-1:0] A_SPEED_WAIT = 5'd10;
    localparam logic [PC_W-1:0] A_NT_COMMIT  = 5'd12;
    localparam logic [PC_W-1:0] A_TICK       = 5'd13;
    localparam logic [PC_W-1:0] A_TICK_WAIT  = 5'd15;
    localparam logic [PC_W-1:0] A_OFS_SET    = 5'd17;
    localparam logic [PC_W-1:0] A_OFS_ADJ    = 5'd18;
    localparam logic [PC_W-1:0] A_DONE       = PC_LAST;

    function automatic cw_t mk(input logic [OP_W-1:0] op, input logic [JC_W-1:0] jc,
                               input logic [PC_W-1:0] target);
        cw_t w;
        w.op     = op;
        w.jc     = jc;
        w.target = target;
        return w;
    endfunction

    always_comb
    begin
        case (pc)
            // dispatch on function code, new target falls through
            5'd0:         cw = mk(OP_NOP,       J_TICK,     A_TICK);
            5'd1:         cw = mk(OP_NOP,       J_SET,      A_OFS_SET);
            5'd2:         cw = mk(OP_NOP,       J_ADJ,      A_OFS_ADJ);
            A_NT:         cw = mk(OP_NT_SP,     J_NEVER,    PC_START);
            5'd4:         cw = mk(OP_NT_UNWRAP, J_NEVER,    PC_START);
            5'd5:         cw = mk(OP_NOP,       J_NO_LIMIT, A_NT_COMMIT);
            5'd6:         cw = mk(OP_DIV_RATE,  J_NEVER,    PC_START);
            A_RATE_WAIT:  cw = mk(OP_NOP,       J_DIV_BUSY, A_RATE_WAIT);
            5'd8:         cw = mk(OP_NOP,       J_RATE_OK,  A_NT_COMMIT);
            5'd9:         cw = mk(OP_DIV_SPEED, J_NEVER,    PC_START);
            A_SPEED_WAIT: cw = mk(OP_NOP,       J_DIV_BUSY, A_SPEED_WAIT);
            5'd11:        cw = mk(OP_SET_IVL,   J_NEVER,    PC_START);
            A_NT_COMMIT:  cw = mk(OP_NT_COMMIT, J_ALWAYS,   A_DONE);
            // tick
            A_TICK:       cw = mk(OP_TICK_MUL,  J_NEVER,    PC_START);
            5'd14:        cw = mk(OP_DIV_TICK,  J_NEVER,    PC_START);
            A_TICK_WAIT:  cw = mk(OP_NOP,       J_DIV_BUSY, A_TICK_WAIT);
            5'd16:        cw = mk(OP_TICK_SP,   J_ALWAYS,   A_DONE);
            // offset
            A_OFS_SET:    cw = mk(OP_OFS_SET,   J_ALWAYS,   A_DONE);
            A_OFS_ADJ:    cw = mk(OP_OFS_ADJ,   J_NEVER,    PC_START);
            A_DONE:       cw = mk(OP_FINISH,    J_OUT_BUSY, A_DONE);
            default:      cw = mk(OP_NOP,       J_ALWAYS,   A_DONE);
        endcase
    end

endmodule

[hw/rtl/wasi_div.sv]
module wasi_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [wasi_pkg::NUM_W-1:0] num,
    input  logic [wasi_pkg::IVL_W-1:0] den,
    output logic                       busy,
    output logic [wasi_pkg::NUM_W-1:0] quo
);
    import wasi_pkg::*;

    // restoring divider, one quotient bit per cycle
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [IVL_W-1:0] rem_reg, rem_next;
    logic [IVL_W-1:0] den_reg, den_next;
    logic [IVL_W:0]   shifted;
    logic             fits;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[NUM_W-1]};
        fits     = shifted >= {1'b0, den_reg};
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        if (start)
        begin
            cnt_next = CNT_W'(NUM_W);
            quo_next = num;
            rem_next = '0;
            den_next = den;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = fits ? IVL_W'(shifted - {1'b0, den_reg}) : shifted[IVL_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = cnt_reg != '0;
    assign quo  = quo_reg;

endmodule

[hw/rtl/wasi_datapath.sv]
module wasi_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  wasi_pkg::ctrl_t                   ctrl,
    input  logic [wasi_pkg::FUNC_W-1:0]       func,
    input  logic [wasi_pkg::DT_W-1:0]         delta_time,
    input  logic [wasi_pkg::ANG_W-1:0]        target_position,
    input  logic signed [wasi_pkg::OFF_W-1:0] new_offset,
    input  logic [wasi_pkg::ANG_W-1:0]        source_position,
    input  logic [wasi_pkg::ANG_W-1:0]        desired_position,
    input  logic [wasi_pkg::SPD_W-1:0]        max_speed,
    input  logic [wasi_pkg::DT_W-1:0]         max_interval,
    output wasi_pkg::stat_t                   stat,
    output logic [wasi_pkg::ANG_W-1:0]        sp,
    output logic [wasi_pkg::OFF_W-1:0]        off
);
    import wasi_pkg::*;

    localparam int UNW_W = PT_W + 2;
    localparam logic signed [UNW_W-1:0] HALF_S  = UNW_W'(HALF_CIRCLE);
    localparam logic [UNW_W-1:0]        CIRC_U  = UNW_W'(CIRCLE_COUNTS);
    localparam logic [PT_W-1:0]         CIRC_PT = PT_W'(CIRCLE_COUNTS);
    localparam logic [IVL_W-1:0]        IVL_ONE = IVL_W'(1);

    // architectural state
    logic [ANG_W-1:0] sp_reg, sp_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic [PT_W-1:0]  prev_reg, prev_next;
    logic [PT_W-1:0]  act_reg, act_next;
    logic [PT_W-1:0]  ext_reg, ext_next;
    logic [IVL_W-1:0] ilen_reg, ilen_next;

    // latched transaction and scratch
    logic [FUNC_W-1:0] func_reg;
    logic [DT_W-1:0]   dt_reg;
    logic [ANG_W-1:0]  tgt_reg, src_reg, des_reg;
    logic [OFF_W-1:0]  noff_reg;
    logic [IVL_W-1:0]  ivl_reg, ivl_next;
    logic [CHG_W-1:0]  chg_reg, chg_next;
    logic [NUM_W-1:0]  prod_reg, prod_next;
    logic              neg_reg, neg_next;

    logic [UNW_W-1:0] unw_c;
    logic [CHG_W-1:0] chg_mag;
    logic [CHG_W-1:0] tdiff, tmag;
    logic [NUM_W-1:0] prod_w;
    logic [OFF_W-1:0] ofs_val;
    logic [ANG_W-1:0] q_low;
    logic [IVL_W-1:0] ivl_stretch;

    logic             div_start, div_busy;
    logic [NUM_W-1:0] div_num, div_q;
    logic [IVL_W-1:0] div_den;

    wasi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (div_q)
    );

    assign chg_mag = chg_reg[CHG_W-1] ? (~chg_reg + 1'b1) : chg_reg;
    assign tdiff   = CHG_W'($signed(ext_reg)) - CHG_W'($signed(prev_reg));
    assign tmag    = tdiff[CHG_W-1] ? (~tdiff + 1'b1) : tdiff;
    assign prod_w  = NUM_W'(tmag[PT_W-1:0]) * NUM_W'(dt_reg);
    assign unw_c   = UNW_W'(sp_reg) - UNW_W'($signed(act_reg));
    assign ofs_val = (ctrl.op == OP_OFS_ADJ) ? (OFF_W'(src_reg) - OFF_W'(des_reg)) : noff_reg;
    assign q_low   = div_q[ANG_W-1:0];
    assign ivl_stretch = IVL_W'(div_q << SPEED_SHIFT);

    assign div_start = (ctrl.op == OP_DIV_RATE) || (ctrl.op == OP_DIV_SPEED) ||
                       (ctrl.op == OP_DIV_TICK);
    assign div_num   = (ctrl.op == OP_DIV_TICK) ? prod_reg : NUM_W'(chg_mag);

    always_comb
    begin
        case (ctrl.op)
            OP_DIV_RATE:  div_den = ivl_reg;
            OP_DIV_SPEED: div_den = IVL_W'(max_speed);
            default:      div_den = ilen_reg;
        endcase
    end

    always_comb
    begin
        sp_next   = sp_reg;
        off_next  = off_reg;
        prev_next = prev_reg;
        act_next  = act_reg;
        ext_next  = ext_reg;
        ilen_next = ilen_reg;
        ivl_next  = ivl_reg;
        chg_next  = chg_reg;
        prod_next = prod_reg;
        neg_next  = neg_reg;
        case (ctrl.op)
            OP_NT_SP:
            begin
                // bad step becomes one; setpoint is target plus offset on the circle
                ivl_next = (dt_reg == '0 || dt_reg > max_interval) ? IVL_ONE
                                                                   : IVL_W'(dt_reg);
                sp_next  = tgt_reg + off_reg[ANG_W-1:0];
            end
            OP_NT_UNWRAP:
            begin
                if ($signed(unw_c) < -HALF_S)
                begin
                    act_next = act_reg - CIRC_PT;
                    ext_next = ext_reg - CIRC_PT;
                    chg_next = CHG_W'(unw_c + CIRC_U);
                end
                else if ($signed(unw_c) > HALF_S)
                begin
                    act_next = act_reg + CIRC_PT;
                    ext_next = ext_reg + CIRC_PT;
                    chg_next = CHG_W'(unw_c - CIRC_U);
                end
                else
                begin
                    chg_next = CHG_W'(unw_c);
                end
            end
            OP_SET_IVL:
            begin
                ivl_next = (ivl_stretch == '0) ? IVL_ONE : ivl_stretch;
            end
            OP_NT_COMMIT:
            begin
                act_next  = PT_W'(sp_reg);
                prev_next = ext_reg;
                ext_next  = PT_W'(sp_reg) + chg_reg[PT_W-1:0];
                ilen_next = ivl_reg;
            end
            OP_TICK_MUL:
            begin
                prod_next = prod_w;
                neg_next  = tdiff[CHG_W-1];
            end
            OP_TICK_SP:
            begin
                // only the low angle bits of the quotient reach the setpoint
                sp_next = prev_reg[ANG_W-1:0] + (neg_reg ? (~q_low + 1'b1) : q_low);
            end
            OP_OFS_SET, OP_OFS_ADJ:
            begin
                prev_next = prev_reg + PT_W'($signed(ofs_val)) - PT_W'($signed(off_reg));
                act_next  = act_reg + PT_W'($signed(ofs_val)) - PT_W'($signed(off_reg));
                off_next  = ofs_val;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg   <= '0;
            off_reg  <= '0;
            prev_reg <= '0;
            act_reg  <= '0;
            ext_reg  <= '0;
            ilen_reg <= IVL_ONE;
        end
        else
        begin
            sp_reg   <= sp_next;
            off_reg  <= off_next;
            prev_reg <= prev_next;
            act_reg  <= act_next;
            ext_reg  <= ext_next;
            ilen_reg <= ilen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            func_reg <= func;
            dt_reg   <= delta_time;
            tgt_reg  <= target_position;
            noff_reg <= new_offset;
            src_reg  <= source_position;
            des_reg  <= desired_position;
        end
        ivl_reg  <= ivl_next;
        chg_reg  <= chg_next;
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
    end

    assign stat.func     = func_reg;
    assign stat.div_busy = div_busy;
    assign stat.rate_ok  = div_q <= NUM_W'(max_speed >> SPEED_SHIFT);
    assign sp            = sp_reg;
    assign off           = off_reg;

    // interval is a divisor and must never be zero
    a_ilen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ilen_reg != '0)
        else $error("interval length is zero");

    // microcode must wait for the divider before reusing it
    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

endmodule

[hw/rtl/wrapped_angle_setpoint_interpolator_top.sv]
// Each function runs its own microcode path; set and adjust offset are the shortest.
// A new target adds a rate divide when the limit is checked and a speed divide when the
// interval is stretched; a tick runs a multiply and one divide. Each divide holds the
// program until the divider is no longer busy. One transaction is in flight at a time;
// the next is taken the cycle after a result is registered.
// Reset: setpoint, offset and points clear to zero, interval to one,
// max_speed to 0, max_interval to 1000.
module wrapped_angle_setpoint_interpolator_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [wasi_pkg::FUNC_W-1:0]          func,
    input  logic [wasi_pkg::DT_W-1:0]            delta_time,
    input  logic [wasi_pkg::ANG_W-1:0]           target_position,
    input  logic signed [wasi_pkg::OFF_W-1:0]    new_offset,
    input  logic [wasi_pkg::ANG_W-1:0]           source_position,
    input  logic [wasi_pkg::ANG_W-1:0]           desired_position,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [wasi_pkg::ANG_W-1:0]           setpoint,
    output logic signed [wasi_pkg::OFF_W-1:0]    current_offset,
    input  logic                                 cfg_write,
    input  logic [wasi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wasi_pkg::DT_W-1:0]            cfg_data
);
    import wasi_pkg::*;

    // Configuration registers
    logic [SPD_W-1:0] max_speed_reg;
    logic [DT_W-1:0]  max_interval_reg;

    // Sequencer: busy flag plus step counter into the microcode table
    logic            busy_reg, busy_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    cw_t             cw;
    ctrl_t           ctrl;
    stat_t           stat;
    logic            take;
    logic            out_blocked;
    logic            finish;
    logic            in_accept;

    // Result register decouples the sequencer from the output stall
    logic             out_valid_reg, out_valid_next;
    logic [ANG_W-1:0] out_sp_reg;
    logic [OFF_W-1:0] out_off_reg;
    logic [ANG_W-1:0] dp_sp;
    logic [OFF_W-1:0] dp_off;

    wasi_ucode_rom u_rom (
        .pc (pc_reg),
        .cw (cw)
    );

    wasi_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (ctrl),
        .func             (func),
        .delta_time       (delta_time),
        .target_position  (target_position),
        .new_offset       (new_offset),
        .source_position  (source_position),
        .desired_position (desired_position),
        .max_speed        (max_speed_reg),
        .max_interval     (max_interval_reg),
        .stat             (stat),
        .sp               (dp_sp),
        .off              (dp_off)
    );

    always_comb
    begin
        out_blocked = out_valid_reg && out_stall;
        case (cw.jc)
            J_NEVER:    take = 1'b0;
            J_ALWAYS:   take = 1'b1;
            J_TICK:     take = stat.func == FN_TICK;
            J_SET:      take = stat.func == FN_SET;
            J_ADJ:      take = stat.func == FN_ADJ;
            J_NO_LIMIT: take = max_speed_reg == '0;
            J_DIV_BUSY: take = stat.div_busy;
            J_RATE_OK:  take = stat.rate_ok;
            J_OUT_BUSY: take = out_blocked;
            default:    take = 1'b0;
        endcase

        in_accept = in_valid && !busy_reg;
        finish    = busy_reg && (cw.op == OP_FINISH) && !out_blocked;

        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (in_accept)
        begin
            busy_next = 1'b1;
            pc_next   = PC_START;
        end
        else if (finish)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            pc_next = take ? cw.target : pc_reg + 1'b1;
        end

        ctrl.load = in_accept;
        ctrl.op   = busy_reg ? cw.op : OP_NOP;

        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            pc_reg           <= PC_START;
            out_valid_reg    <= 1'b0;
            max_speed_reg    <= MAX_SPEED_RST;
            max_interval_reg <= MAX_INTERVAL_RST;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_MAX_SPEED:    max_speed_reg    <= cfg_data[SPD_W-1:0];
                    REG_MAX_INTERVAL: max_interval_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_sp_reg  <= dp_sp;
            out_off_reg <= dp_off;
        end
    end

    assign in_stall       = busy_reg;
    assign out_valid      = out_valid_reg;
    assign setpoint       = out_sp_reg;
    assign current_offset = out_off_reg;

    // an accepted transaction always starts the program at its entry step
    a_start_at_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (busy_reg && pc_reg == PC_START))
        else $error("transaction did not start at program entry");

    // a result appears only as the sequencer retires its transaction
    a_result_on_retire: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(busy_reg) && !busy_reg))
        else $error("result registered without retiring a transaction");

    // jumps never leave the program
    a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pc_reg <= PC_LAST))
        else $error("step counter outside program");

endmodule

[bench/testbench.sv]
module testbench;
    import wasi_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 6;
    // Slowest legal run is roughly 1400 transactions; the cycle limit gives it
    // ample room before declaring a hang.
    localparam longint LIMIT_CYCLES = 1_500_000;
    localparam int DIR_N        = 29;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 225;
    // Settling time after the last result before a register write
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 100;

    // One input transaction as the block sees it
    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic [DT_W-1:0]         dt;
        logic [ANG_W-1:0]        tgt;
        logic signed [OFF_W-1:0] noff;
        logic [ANG_W-1:0]        src;
        logic [ANG_W-1:0]        des;
    } angle_cmd_t;

    // One output transaction
    typedef struct packed {
        logic [ANG_W-1:0]        sp;
        logic signed [OFF_W-1:0] ofs;
    } angle_result_t;

    // Directed table row: either a register write (value carried in cmd.dt)
    // or a transaction, optionally with a hand-written expected result.
    typedef struct packed {
        logic                    is_cfg;
        logic [CFG_IDX_W-1:0]    reg_idx;
        angle_cmd_t              cmd;
        logic                    typed;
        logic [ANG_W-1:0]        sp;
        logic signed [OFF_W-1:0] ofs;
    } row_t;

    logic                    clk              = 1'b0;
    logic                    rst_n            = 1'b0;
    logic                    in_valid         = 1'b0;
    logic                    in_stall;
    logic [FUNC_W-1:0]       func             = FN_TICK;
    logic [DT_W-1:0]         delta_time       = '0;
    logic [ANG_W-1:0]        target_position  = '0;
    logic signed [OFF_W-1:0] new_offset       = '0;
    logic [ANG_W-1:0]        source_position  = '0;
    logic [ANG_W-1:0]        desired_position = '0;
    logic                    out_valid;
    logic                    out_stall        = 1'b0;
    logic [ANG_W-1:0]        setpoint;
    logic signed [OFF_W-1:0] current_offset;
    logic                    cfg_write        = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index        = REG_MAX_SPEED;
    logic [DT_W-1:0]         cfg_data         = '0;

    wrapped_angle_setpoint_interpolator_top u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .func             (func),
        .delta_time       (delta_time),
        .target_position  (target_position),
        .new_offset       (new_offset),
        .source_position  (source_position),
        .desired_position (desired_position),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .setpoint         (setpoint),
        .current_offset   (current_offset),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // Free-running clock, 50% duty
    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: mirror of the block's registers and configuration.
    // Points live in 16-bit two's complement, offset in 13-bit.
    // ------------------------------------------------------------------
    int     spd_lim  = 0;
    int     ivl_max  = 1000;
    int     sp_now   = 0;
    int     ofs_now  = 0;
    int     prev_pt  = 0;
    int     act_pt   = 0;
    int     ext_pt   = 0;
    longint ivl_len  = 1;

    angle_result_t pending_results[$];
    int            mismatches = 0;

    // Sender burst shaping
    int unsigned burst_left = 0;
    int unsigned gap_len    = 0;

    // Receiver stall pattern
    int unsigned stall_mode = 0;
    int unsigned stall_span = 0;

    row_t dir_rows [DIR_N];

    function automatic int wrap_pt(longint v);
        logic signed [PT_W-1:0] t;
        t = v[PT_W-1:0];
        return int'(t);
    endfunction

    function automatic int wrap_ofs(longint v);
        logic signed [OFF_W-1:0] t;
        t = v[OFF_W-1:0];
        return int'(t);
    endfunction

    // Reduce to [0, CIRCLE_COUNTS); % truncates toward zero like the hardware spec
    function automatic int on_circle(longint v);
        longint r;
        r = v % longint'(CIRCLE_COUNTS);
        if (r < 0)
            r += CIRCLE_COUNTS;
        return int'(r);
    endfunction

    // Offset change shifts previous and actual points; extrapolated stays put
    function automatic void shift_by_offset(int value);
        longint d;
        d = longint'(value) - longint'(ofs_now);
        prev_pt = wrap_pt(longint'(prev_pt) + d);
        act_pt  = wrap_pt(longint'(act_pt) + d);
        ofs_now = value;
    endfunction

    function automatic void plan_new_target(longint dt, int tgt);
        longint span, step, change, rate, t;
        span = dt;
        // Bad step: zero or over the limit collapses to one
        if (span == 0 || span > longint'(ivl_max))
            span = 1;

        // Shortest path from the actual point, then offset and wrap
        step = longint'(tgt) - longint'(act_pt);
        if (step < -HALF_CIRCLE)
            step += CIRCLE_COUNTS;
        else if (step > HALF_CIRCLE)
            step -= CIRCLE_COUNTS;
        sp_now = on_circle(longint'(act_pt) + step + longint'(ofs_now));

        // Unwrap actual and extrapolated points toward the new setpoint (one turn max)
        change = longint'(sp_now) - longint'(act_pt);
        if (change < -HALF_CIRCLE)
        begin
            act_pt = wrap_pt(longint'(act_pt) - CIRCLE_COUNTS);
            ext_pt = wrap_pt(longint'(ext_pt) - CIRCLE_COUNTS);
            change = longint'(sp_now) - longint'(act_pt);
        end
        else if (change > HALF_CIRCLE)
        begin
            act_pt = wrap_pt(longint'(act_pt) + CIRCLE_COUNTS);
            ext_pt = wrap_pt(longint'(ext_pt) + CIRCLE_COUNTS);
            change = longint'(sp_now) - longint'(act_pt);
        end

        // Speed limit: signed truncating division for the rate test and the stretch
        if (spd_lim > 0)
        begin
            rate = change / span;
            if (rate < 0)
                rate = -rate;
            if (rate > longint'(spd_lim / SPEED_UNIT))
            begin
                t = change / longint'(spd_lim) * SPEED_UNIT;
                if (t < 0)
                    t = -t;
                span = t & 64'h1_FFFF;
            end
        end
        // Zero interval after stretching is held at one
        if (span == 0)
            span = 1;

        act_pt  = sp_now;
        prev_pt = ext_pt;
        ext_pt  = wrap_pt(longint'(act_pt) + change);
        ivl_len = span;
    endfunction

    // Linear interpolation, not clamped to the interval
    function automatic void plan_tick(longint dt);
        longint len, diff;
        len  = (ivl_len != 0) ? ivl_len : 1;
        diff = longint'(ext_pt) - longint'(prev_pt);
        sp_now = on_circle(longint'(prev_pt) + (diff * dt) / len);
    endfunction

    // Apply one accepted transaction to the mirror and return its result
    function automatic angle_result_t advance_angle_state(angle_cmd_t c);
        angle_result_t r;
        case (c.func)
            FN_TARGET: plan_new_target(longint'(c.dt), int'(c.tgt));
            FN_TICK:   plan_tick(longint'(c.dt));
            FN_SET:    shift_by_offset(int'(c.noff));
            default:   shift_by_offset(wrap_ofs(longint'(on_circle(longint'(c.src)))
                                                - longint'(on_circle(longint'(c.des)))));
        endcase
        r.sp  = ANG_W'(sp_now);
        r.ofs = OFF_W'(ofs_now);
        return r;
    endfunction

    function automatic angle_cmd_t random_cmd();
        angle_cmd_t c;
        int pick;
        int jitter;
        int raw_off;
        pick = int'($urandom_range(0, 99));
        if (pick < 45)
            c.func = FN_TARGET;
        else if (pick < 85)
            c.func = FN_TICK;
        else if (pick < 93)
            c.func = FN_SET;
        else
            c.func = FN_ADJ;

        case ($urandom_range(0, 9))
            0:       c.dt = '0;
            1:       c.dt = '1;
            2, 3:    c.dt = DT_W'($urandom);
            default: c.dt = DT_W'($urandom_range(1, 1200));
        endcase

        // Mostly targets near the current position so the speed test sees
        // small changes too, the rest anywhere on the circle
        if ($urandom_range(0, 2) == 0)
            c.tgt = ANG_W'($urandom);
        else
        begin
            jitter = int'($urandom_range(0, 400)) - 200;
            c.tgt = ANG_W'(on_circle(longint'(act_pt) - longint'(ofs_now) + jitter));
        end

        raw_off = int'($urandom_range(0, 8190)) - 4095;
        c.noff  = OFF_W'(raw_off);
        c.src   = ANG_W'($urandom);
        c.des   = ANG_W'($urandom);
        return c;
    endfunction

    // Drive one transaction from a falling edge, hold it until accepted,
    // record the expected result, then apply the sender's burst/gap pattern.
    task automatic send_cmd(input angle_cmd_t c, input logic typed,
                            input logic [ANG_W-1:0] sp_t,
                            input logic signed [OFF_W-1:0] ofs_t);
        angle_result_t r;
        func             <= c.func;
        delta_time       <= c.dt;
        target_position  <= c.tgt;
        new_offset       <= c.noff;
        source_position  <= c.src;
        desired_position <= c.des;
        in_valid         <= 1'b1;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        r = advance_angle_state(c);
        if (typed)
        begin
            r.sp  = sp_t;
            r.ofs = ofs_t;
        end
        pending_results.push_back(r);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            // Occasionally a long back-to-back stretch, otherwise short bursts
            if ($urandom_range(0, 5) == 0)
            begin
                burst_left = 100;
                gap_len    = 0;
            end
            else
            begin
                burst_left = $urandom_range(0, 30);
                gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
            end
            if (gap_len > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap_len) @(negedge clk);
            end
        end
    endtask

    // Register write only with the block idle: stop sending, wait for every
    // outstanding result, let it settle, then write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DT_W-1:0] val);
        if (in_valid)
            in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_MAX_SPEED)
            spd_lim = int'(val[SPD_W-1:0]);
        else
            ivl_max = int'(val);
    endtask

    // Receiver: stall pattern switches between free flow, random stalls and
    // heavy stalls, each held for a random span.
    always @(negedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_span = $urandom_range(20, 300);
        end
        else
            stall_span--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 2) == 0);
            default: out_stall <= ($urandom_range(0, 15) != 0);
        endcase
    end

    // Result checker: every accepted output transaction against the oldest expectation
    always @(posedge clk)
    begin : result_check
        angle_result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t unexpected result: setpoint %0d offset %0d",
                             $time, setpoint, current_offset);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (setpoint !== want.sp || current_offset !== want.ofs)
                begin
                    if (mismatches < 10)
                        $display("%0t result mismatch: setpoint exp %0d got %0d, offset exp %0d got %0d",
                                 $time, want.sp, setpoint, want.ofs, current_offset);
                    mismatches++;
                end
            end
        end
    end

    // Hang guard
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("[wrapped_angle_setpoint_interpolator_top] ERROR");
        $finish;
    end

    initial
    begin
        // Directed table. Hand-written results only where obvious: right
        // after reset and for pure offset writes from the origin.
        dir_rows = '{
            // tick from reset state: nothing moves
            '{1'b0, REG_MAX_SPEED, '{FN_TICK, 16'd0, 12'd0, 13'sd0, 12'd0, 12'd0},
              1'b1, 12'd0, 13'sd0},
            // offset extremes
            '{1'b0, REG_MAX_SPEED, '{FN_SET, 16'd0, 12'd0, 13'sd4095, 12'd0, 12'd0},
              1'b1, 12'd0, 13'sd4095},
            '{1'b0, REG_MAX_SPEED, '{FN_SET, 16'd0, 12'd0, -13'sd4095, 12'd0, 12'd0},
              1'b1, 12'd0, -13'sd4095},
            '{1'b0, REG_MAX_SPEED, '{FN_ADJ, 16'd0, 12'd0, 13'sd0, 12'd0, 12'd0},
              1'b1, 12'd0, 13'sd0},
            // bad step: zero, then above the interval limit
            '{1'b0, REG_MAX_SPEED, '{FN_TARGET, 16'd0, 12'd4095, 13'sd0, 12'd0, 12'd0},
              1'b0, 12'd0, 13'sd0},
            '{1'b0, REG_MAX_SPEED, '{FN_TARGET, 16'hFFFF, 12'd0, 13'sd0, 12'd0, 12'd0},
              1'b0, 12'd0, 13'sd0},
            // exactly half a turn
            '{1'b0, REG_MAX_SPEED, '{FN_TARGET, 16'd1000, 12'd2048, 13'sd0, 12'd0, 12'd0},
              1'b0, 12'd0, 13'sd0},
            // tick far past the interval, then inside it
            '{1'b0, REG_MAX_SPEED, '{FN_TICK, 16'hFFFF, 12'd0, 13'sd0, 12'd0, 12'd0},
              1'b0, 12'd0, 13'sd0},
            '{1'b0, REG_MAX_SPEED, '{FN_TICK, 16'd500, 12'd0, 13'sd0, 12'd0, 12'd0},
              1'b0, 12'd0, 13'sd0},
            // offset derived from position extremes, both directions
            '{1'b0, REG_MAX_SPEED, '{FN_ADJ, 16'd0, 12'd0, 13'sd0, 12'd4095, 12'd0},
              1'b0, 12'd0, 13'sd0},
            '{1'b0, REG_MAX_SPEED, '{FN_ADJ, 16'd0, 12'd0, 13'sd0, 12'd0, 12'd4095},
              1'b0, 12'd0, 13'sd0},
            '{1'b0, REG_MAX_SPEED, '{FN_SET, 16'd0, 12'd0, 13'sd1234, 12'd0, 12'd0},
              1'b0, 12'd0, 13'sd0},
            '{1'b0, REG_MAX_SPEED, '{FN_TARGET, 16'd1, 12'd3000, 13'sd0, 12'd0, 12'd0},
              1'b0, 12'd0, 13'sd0},
            // fastest speed limit: small change stretched to zero, held at one
            '{1'b1, REG_MAX_SPEED, '{FN_TICK, 16'd255, 12'd0, 13'sd0, 12'd0, 12'd0},
              1'b0, 12'd0, 13'sd0},
            '{1'b0, REG_MAX_SPEED, '{FN_TARGET, 16'd1, 12'd3100, 13'sd0, 12'd0, 12'd0},
              1'b0, 12'd0, 13'sd0},
            '{1'b0, REG_MAX_SPEED, '{FN_TARGET, 16'd1, 12'd2000, 13'sd0, 12'd0, 12'd0},
              1'b0, 12'd0, 13'sd0},
            '{1'b0, REG_MAX_SPEED, '{FN_TICK, 16'd1234, 12'd0, 13'sd0, 12'd0, 12'd0},
              1'b0, 12'd0, 13'sd0},
            // slowest speed limit: long stretched interval
            '{1'b1, REG_MAX_SPEED, '{FN_TICK, 16'd1, 12'd0, 13'sd0, 12'd0, 12'd0},
              1'b0, 12'd0, 13'sd0},
            '{1'b0, REG_MAX_SPEED, '{FN_TARGET, 16'hFFFF, 12'd4000, 13'sd0, 12'd0, 12'd0},
              1'b0, 12'd0, 13'sd0},
            '{1'b0, REG_MAX_SPEED, '{FN_TICK, 16'd40000, 12'd0, 13'sd0, 12'd0, 12'd0},
              1'b0, 12'd0, 13'sd0},
            // widest interval limit
            '{1'b1, REG_MAX_INTERVAL, '{FN_TICK, 16'hFFFF, 12'd0, 13'sd0, 12'd0, 12'd0},
              1'b0, 12'd0, 13'sd0},
            '{1'b0, REG_MAX_SPEED, '{FN_TARGET, 16'hFFFF, 12'd1, 13'sd0, 12'd0, 12'd0},
              1'b0, 12'd0, 13'sd0},
            '{1'b0, REG_MAX_SPEED, '{FN_TICK, 16'hFFFF, 12'd0, 13'sd0, 12'd0, 12'd0},
              1'b0, 12'd0, 13'sd0},
            // narrowest interval limit: any step above one is bad
            '{1'b1, REG_MAX_INTERVAL, '{FN_TICK, 16'd1, 12'd0, 13'sd0, 12'd0, 12'd0},
              1'b0, 12'd0, 13'sd0},
            '{1'b0, REG_MAX_SPEED, '{FN_TARGET, 16'd2, 12'd2047, 13'sd0, 12'd0, 12'd0},
              1'b0, 12'd0, 13'sd0},
            '{1'b0, REG_MAX_SPEED, '{FN_SET, 16'd0, 12'd0, 13'sd0, 12'd0, 12'd0},
              1'b0, 12'd0, 13'sd0},
            // back to reset configuration
            '{1'b1, REG_MAX_SPEED, '{FN_TICK, 16'd0, 12'd0, 13'sd0, 12'd0, 12'd0},
              1'b0, 12'd0, 13'sd0},
            '{1'b1, REG_MAX_INTERVAL, '{FN_TICK, 16'd1000, 12'd0, 13'sd0, 12'd0, 12'd0},
              1'b0, 12'd0, 13'sd0},
            '{1'b0, REG_MAX_SPEED, '{FN_TARGET, 16'd7, 12'd4095, 13'sd0, 12'd0, 12'd0},
              1'b0, 12'd0, 13'sd0}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                write_reg(dir_rows[i].reg_idx, dir_rows[i].cmd.dt);
            else
                send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].sp, dir_rows[i].ofs);
        end

        // Random phases, each under its own configuration; the block drains
        // completely before every reconfiguration.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(REG_MAX_SPEED, 16'd0);
                    write_reg(REG_MAX_INTERVAL, 16'd1000);
                end
                1:
                begin
                    write_reg(REG_MAX_SPEED, 16'd255);
                    write_reg(REG_MAX_INTERVAL, 16'hFFFF);
                end
                2:
                begin
                    write_reg(REG_MAX_SPEED, 16'd1);
                    write_reg(REG_MAX_INTERVAL, 16'd1);
                end
                3:
                begin
                    write_reg(REG_MAX_SPEED, 16'd32);
                    write_reg(REG_MAX_INTERVAL, 16'd200);
                end
                4:
                begin
                    write_reg(REG_MAX_SPEED, 16'd7);
                    write_reg(REG_MAX_INTERVAL, DT_W'($urandom_range(1, 3000)));
                end
                default:
                begin
                    write_reg(REG_MAX_SPEED, DT_W'($urandom_range(1, 255)));
                    write_reg(REG_MAX_INTERVAL, DT_W'($urandom_range(1, 65535)));
                end
            endcase
            repeat (PHASE_ITEMS)
                send_cmd(random_cmd(), 1'b0, '0, '0);
        end

        if (in_valid)
            in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // Watch a while longer for stray output transactions
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[wrapped_angle_setpoint_interpolator_top] OK");
        else
            $display("[wrapped_angle_setpoint_interpolator_top] ERROR");
        $finish;
    end

endmodule
